### rtl/ers_pkg.sv
// Shared types and constants for the e-paper render scheduler.
package ers_pkg;

	localparam int unsigned TS_W = 32;
	localparam int unsigned SCR_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned CNT_W = 8;

	typedef enum logic [2:0] {
		MODE_DETENT = 3'd0,
		MODE_INTENT = 3'd1,
		MODE_DONE   = 3'd2,
		MODE_TICK   = 3'd3,
		MODE_CLEAR  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CFG_DWELL    = 2'd0,
		CFG_COALESCE = 2'd1,
		CFG_FULL_N   = 2'd2
	} cfg_idx_t;

	localparam logic [KIND_W-1:0] KIND_FAST = 2'd0;
	localparam logic [KIND_W-1:0] KIND_COLOUR = 2'd1;

	typedef struct packed {
		logic [2:0]        mode;
		logic [SCR_W-1:0]  screen_id;
		logic              attention;
		logic [KIND_W-1:0] kind;
		logic [TS_W-1:0]   now_ms;
	} event_t;

	typedef struct packed {
		logic [TS_W-1:0]  dwell_ms;
		logic [TS_W-1:0]  coalesce_ms;
		logic [CNT_W-1:0] full_every_n;
	} cfg_t;

	typedef struct packed {
		logic              render;
		logic [SCR_W-1:0]  screen;
		logic [KIND_W-1:0] render_kind;
		logic              full_clear;
		logic              cleared;
	} result_t;

endpackage

### rtl/ers_core.sv
// Scheduler state and the per-event decision logic.
module ers_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  ers_pkg::event_t ev,
	input  ers_pkg::cfg_t   cfg,
	output ers_pkg::result_t res
);
	import ers_pkg::*;

	logic              busy_q, pend_valid_q, pend_att_q, dwell_armed_q;
	logic              amb_ever_q, inflight_amb_q;
	logic [SCR_W-1:0]  pend_screen_q, dwell_screen_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [TS_W-1:0]   dwell_stamp_q, amb_stamp_q;
	logic [CNT_W-1:0]  rsc_q;

	logic              busy_d, pend_valid_d, pend_att_d, dwell_armed_d;
	logic              amb_ever_d, inflight_amb_d;
	logic [SCR_W-1:0]  pend_screen_d, dwell_screen_d;
	logic [KIND_W-1:0] pend_kind_d;
	logic [TS_W-1:0]   dwell_stamp_d, amb_stamp_d;
	logic [CNT_W-1:0]  rsc_d, rsc_inc;

	logic [TS_W-1:0] dwell_diff, dwell_age, amb_age;
	logic            dwell_ok, amb_ok;

	// a detent stamped in the future (top bit set) counts as no time elapsed
	assign dwell_diff = ev.now_ms - dwell_stamp_q;
	assign dwell_age  = dwell_diff[TS_W-1] ? '0 : dwell_diff;
	assign amb_age    = ev.now_ms - amb_stamp_q;
	assign dwell_ok   = dwell_armed_q && (dwell_age >= cfg.dwell_ms);
	assign amb_ok     = pend_valid_q && (!amb_ever_q || (amb_age >= cfg.coalesce_ms));
	assign rsc_inc    = rsc_q + CNT_W'(1);

	always_comb begin
		res            = '0;
		busy_d         = busy_q;
		pend_valid_d   = pend_valid_q;
		pend_att_d     = pend_att_q;
		pend_screen_d  = pend_screen_q;
		pend_kind_d    = pend_kind_q;
		dwell_armed_d  = dwell_armed_q;
		dwell_stamp_d  = dwell_stamp_q;
		dwell_screen_d = dwell_screen_q;
		amb_stamp_d    = amb_stamp_q;
		amb_ever_d     = amb_ever_q;
		inflight_amb_d = inflight_amb_q;
		rsc_d          = rsc_q;
		unique case (ev.mode)
			MODE_DETENT: begin
				dwell_armed_d  = 1'b1;
				dwell_stamp_d  = ev.now_ms;
				dwell_screen_d = ev.screen_id;
			end
			MODE_INTENT: begin
				// ambient never displaces a pending attention intent
				if (ev.attention || !pend_valid_q || !pend_att_q) begin
					pend_valid_d  = 1'b1;
					pend_screen_d = ev.screen_id;
					pend_kind_d   = ev.kind;
					pend_att_d    = ev.attention;
				end
			end
			MODE_DONE: begin
				if (busy_q) begin
					busy_d = 1'b0;
					if (inflight_amb_q) begin
						amb_stamp_d    = ev.now_ms;
						amb_ever_d     = 1'b1;
						inflight_amb_d = 1'b0;
					end
				end
			end
			MODE_TICK: begin
				if (!busy_q) begin
					priority if (pend_valid_q && pend_att_q) begin
						res.render     = 1'b1;
						res.screen     = pend_screen_q;
						res.render_kind = pend_kind_q;
						pend_valid_d   = 1'b0;
						inflight_amb_d = 1'b0;
					end else if (dwell_ok) begin
						res.render     = 1'b1;
						res.screen     = dwell_screen_q;
						res.render_kind = KIND_FAST;
						dwell_armed_d  = 1'b0;
						inflight_amb_d = 1'b0;
					end else if (amb_ok) begin
						res.render     = 1'b1;
						res.screen     = pend_screen_q;
						res.render_kind = pend_kind_q;
						pend_valid_d   = 1'b0;
						inflight_amb_d = 1'b1;
					end else begin
						res.render = 1'b0;
					end
					if (res.render) begin
						busy_d = 1'b1;
						if (res.render_kind != KIND_COLOUR && cfg.full_every_n != '0) begin
							if (rsc_inc >= cfg.full_every_n) begin
								res.full_clear = 1'b1;
								rsc_d          = '0;
							end else begin
								rsc_d = rsc_inc;
							end
						end
					end
				end
			end
			MODE_CLEAR: begin
				if (pend_valid_q && !pend_att_q) begin
					pend_valid_d = 1'b0;
					res.cleared  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			pend_valid_q   <= 1'b0;
			pend_att_q     <= 1'b0;
			pend_screen_q  <= '0;
			pend_kind_q    <= '0;
			dwell_armed_q  <= 1'b0;
			dwell_stamp_q  <= '0;
			dwell_screen_q <= '0;
			amb_stamp_q    <= '0;
			amb_ever_q     <= 1'b0;
			inflight_amb_q <= 1'b0;
			rsc_q          <= '0;
		end else if (fire) begin
			busy_q         <= busy_d;
			pend_valid_q   <= pend_valid_d;
			pend_att_q     <= pend_att_d;
			pend_screen_q  <= pend_screen_d;
			pend_kind_q    <= pend_kind_d;
			dwell_armed_q  <= dwell_armed_d;
			dwell_stamp_q  <= dwell_stamp_d;
			dwell_screen_q <= dwell_screen_d;
			amb_stamp_q    <= amb_stamp_d;
			amb_ever_q     <= amb_ever_d;
			inflight_amb_q <= inflight_amb_d;
			rsc_q          <= rsc_d;
		end
	end

	a_render_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.render |=> busy_q)
		else $error("render issued but panel not marked busy");
	a_no_render_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && busy_q |-> !res.render)
		else $error("render issued while panel busy");
	a_clear_drops_pending: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.cleared |=> !pend_valid_q)
		else $error("cleared reported but pending intent kept");
	a_full_resets_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.full_clear |=> rsc_q == '0)
		else $error("full clear issued without counter restart");

endmodule

### rtl/ers_out_buf.sv
// Two-entry result buffer between the decision stage and the output port.
module ers_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ers_pkg::result_t din,
	input  logic             pop,
	output ers_pkg::result_t dout,
	output logic             valid,
	output logic             full
);
	import ers_pkg::*;

	result_t    e0_q, e1_q;
	logic [1:0] count_q;

	assign dout  = e0_q;
	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) e0_q <= din;
				else e1_q <= din;
			end
			2'b01: begin
				e0_q <= e1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					e0_q <= din;
				end else begin
					e0_q <= e1_q;
					e1_q <= din;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/epaper_render_scheduler.sv
// Top level of the e-paper render scheduler: ports, input stage, config registers.
//
//  channel | dir | handshake        | payload
//  s_      | in  | s_tvalid/tready  | tuser: mode; tdata: screen_id, attention, kind, now_ms
//  m_      | out | m_tvalid/tready  | tdata: render, screen, render_kind, full_clear, cleared
//  cfg_    | in  | cfg_we           | cfg_index, cfg_data
//
// Each item yields one result: the item is held in the input register, then the
// decision logic writes its result into the result buffer; one item per cycle while the buffer is not full.
// Reset clears all scheduler state and the config registers to zero.
// The two-entry result buffer lets input flow continue while one result waits;
// s_tready drops only when the input stage holds an item and the buffer is full.
module epaper_render_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // screen_id[7:0], attention[8], kind[10:9], now_ms[42:11]
	input  logic [2:0]  s_tuser,  // mode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // render[0], screen[8:1], render_kind[10:9],
	                              // full_clear[11], cleared[12]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import ers_pkg::*;

	cfg_t    cfg_q;
	event_t  ev_s1;
	logic    v_s1;
	logic    fire, buf_full;
	result_t res, out_res;

	assign fire     = v_s1 && !buf_full;
	assign s_tready = !v_s1 || !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DWELL:    cfg_q.dwell_ms <= cfg_data;
				CFG_COALESCE: cfg_q.coalesce_ms <= cfg_data;
				CFG_FULL_N:   cfg_q.full_every_n <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1.mode      <= s_tuser;
			ev_s1.screen_id <= s_tdata[7:0];
			ev_s1.attention <= s_tdata[8];
			ev_s1.kind      <= s_tdata[10:9];
			ev_s1.now_ms    <= s_tdata[42:11];
		end
	end

	ers_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ev     (ev_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	ers_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.din    (res),
		.pop    (m_tvalid && m_tready),
		.dout   (out_res),
		.valid  (m_tvalid),
		.full   (buf_full)
	);

	assign m_tdata = {3'b000, out_res.cleared, out_res.full_clear, out_res.render_kind,
		out_res.screen, out_res.render};

endmodule

### tb/tb_top.sv
// Self-checking testbench for the e-paper render scheduler.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ers_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index, writes are dropped
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_AFTER = 250;          // results seen before the long output hold
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 100;

	// Tracks the scheduler state and keeps the commands it should issue, in order.
	class render_sched_model;
		logic [TS_W-1:0]   dwell_ms;
		logic [TS_W-1:0]   coalesce_ms;
		logic [CNT_W-1:0]  full_n;
		bit                busy;
		bit                pend_v;
		bit                pend_att;
		logic [SCR_W-1:0]  pend_scr;
		logic [KIND_W-1:0] pend_kind;
		bit                dwell_armed;
		logic [TS_W-1:0]   dwell_stamp;
		logic [SCR_W-1:0]  dwell_scr;
		logic [TS_W-1:0]   amb_stamp;
		bit                amb_seen;
		bit                inflight_amb;
		logic [CNT_W-1:0]  since_clear;
		result_t           cmd_q[$];
		int                errors;

		function new();
			dwell_ms = '0;
			coalesce_ms = '0;
			full_n = '0;
			busy = 0;
			pend_v = 0;
			pend_att = 0;
			pend_scr = '0;
			pend_kind = '0;
			dwell_armed = 0;
			dwell_stamp = '0;
			dwell_scr = '0;
			amb_stamp = '0;
			amb_seen = 0;
			inflight_amb = 0;
			since_clear = '0;
			errors = 0;
		endfunction

		function int pending();
			return cmd_q.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				CFG_DWELL:    dwell_ms = val;
				CFG_COALESCE: coalesce_ms = val;
				CFG_FULL_N:   full_n = val[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_event(event_t ev);
			result_t r;
			logic [TS_W-1:0] age;
			logic [TS_W-1:0] since_amb;
			logic [CNT_W-1:0] nxt;
			r = '0;
			case (ev.mode)
				MODE_DETENT: begin
					dwell_armed = 1;
					dwell_stamp = ev.now_ms;
					dwell_scr = ev.screen_id;
				end
				MODE_INTENT: begin
					// ambient never displaces a waiting attention intent
					if (ev.attention || !pend_v || !pend_att) begin
						pend_v = 1;
						pend_scr = ev.screen_id;
						pend_kind = ev.kind;
						pend_att = ev.attention;
					end
				end
				MODE_DONE: begin
					if (busy) begin
						busy = 0;
						if (inflight_amb) begin
							amb_stamp = ev.now_ms;
							amb_seen = 1;
							inflight_amb = 0;
						end
					end
				end
				MODE_TICK: begin
					if (!busy) begin
						age = ev.now_ms - dwell_stamp;
						if (age[TS_W-1])
							age = '0;  // detent stamped in the future
						since_amb = ev.now_ms - amb_stamp;
						if (pend_v && pend_att) begin
							r.render = 1;
							r.screen = pend_scr;
							r.render_kind = pend_kind;
							pend_v = 0;
							inflight_amb = 0;
						end else if (dwell_armed && age >= dwell_ms) begin
							r.render = 1;
							r.screen = dwell_scr;
							r.render_kind = KIND_FAST;
							dwell_armed = 0;
							inflight_amb = 0;
						end else if (pend_v && (!amb_seen || since_amb >= coalesce_ms)) begin
							r.render = 1;
							r.screen = pend_scr;
							r.render_kind = pend_kind;
							pend_v = 0;
							inflight_amb = 1;
						end
						if (r.render) begin
							busy = 1;
							if (r.render_kind != KIND_COLOUR && full_n != '0) begin
								nxt = since_clear + 1'b1;
								if (nxt >= full_n) begin
									r.full_clear = 1;
									since_clear = '0;
								end else begin
									since_clear = nxt;
								end
							end
						end
					end
				end
				MODE_CLEAR: begin
					if (pend_v && !pend_att) begin
						pend_v = 0;
						r.cleared = 1;
					end
				end
				default: ;
			endcase
			cmd_q.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (cmd_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result %h", $realtime, got);
				return;
			end
			exp_r = cmd_q.pop_front();
			if (got.render !== exp_r.render || got.screen !== exp_r.screen ||
				got.render_kind !== exp_r.render_kind ||
				got.full_clear !== exp_r.full_clear || got.cleared !== exp_r.cleared) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp render=%b scr=%h kind=%0d fc=%b clr=%b, got render=%b scr=%h kind=%0d fc=%b clr=%b",
						$realtime, exp_r.render, exp_r.screen, exp_r.render_kind,
						exp_r.full_clear, exp_r.cleared, got.render, got.screen,
						got.render_kind, got.full_clear, got.cleared);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	render_sched_model model = new();
	event_t  seen_ev;
	result_t got_res;
	int      results_seen;
	int      quiet_cycles;
	logic [TS_W-1:0] stamp_ms;
	int unsigned     step_max;

	epaper_render_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// input monitor: every accepted item goes through the predictor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			seen_ev.mode = s_tuser;
			seen_ev.screen_id = s_tdata[7:0];
			seen_ev.attention = s_tdata[8];
			seen_ev.kind = s_tdata[10:9];
			seen_ev.now_ms = s_tdata[42:11];
			model.note_event(seen_ev);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.render = m_tdata[0];
			got_res.screen = m_tdata[8:1];
			got_res.render_kind = m_tdata[10:9];
			got_res.full_clear = m_tdata[11];
			got_res.cleared = m_tdata[12];
			model.check_result(got_res);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: segments of always-ready, random and mostly-stalled, plus one long hold
	initial begin : receiver
		int seg_len;
		int seg_kind;
		bit held;
		held = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			seg_len = $urandom_range(10, 60);
			seg_kind = $urandom_range(0, 2);
			repeat (seg_len) begin
				@(negedge clk);
				if (!held && results_seen >= HOLD_AFTER) begin
					held = 1;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
				end else begin
					case (seg_kind)
						0: m_tready <= 1'b1;
						1: m_tready <= ($urandom_range(0, 1) == 1);
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	task automatic send_event(logic [2:0] mode, logic [7:0] sid, logic att,
		logic [1:0] kind, logic [31:0] now);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {5'd0, now, kind, att, sid};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_input(int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// wait until every command has come back, then give the pipeline a margin
	task automatic wait_drained();
		while (model.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		model.write_reg(idx, val);
	endtask

	task automatic program_regs(logic [31:0] dwell, logic [31:0] coal, logic [7:0] n);
		write_reg(CFG_DWELL, dwell);
		write_reg(CFG_COALESCE, coal);
		write_reg(CFG_FULL_N, {24'(~n), n});  // upper bits must be dropped
		if ($urandom_range(0, 1) == 1)
			write_reg(CFG_SPARE, $urandom);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [2:0] pick_mode();
		int w;
		w = $urandom_range(0, 99);
		if (w < 35) return MODE_TICK;
		if (w < 55) return MODE_DONE;
		if (w < 77) return MODE_INTENT;
		if (w < 89) return MODE_DETENT;
		if (w < 97) return MODE_CLEAR;
		return MODE_CLEAR + 3'($urandom_range(1, 3));
	endfunction

	function automatic void advance_clock();
		int w;
		w = $urandom_range(0, 99);
		if (w < 80)
			stamp_ms = stamp_ms + $urandom_range(0, step_max);
		else if (w < 92)
			;
		else if (w < 96)
			stamp_ms = stamp_ms - $urandom_range(1, 50);  // clock seen going back
		else
			stamp_ms = $urandom;
	endfunction

	task automatic run_phase(logic [31:0] dwell, logic [31:0] coal, logic [7:0] n,
		logic [31:0] base, int unsigned step);
		int burst_left;
		program_regs(dwell, coal, n);
		stamp_ms = base;
		step_max = step;
		burst_left = $urandom_range(1, 24);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			advance_clock();
			send_event(pick_mode(), 8'($urandom), ($urandom_range(0, 4) < 2),
				2'($urandom_range(0, 3)), stamp_ms);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0)
					idle_input($urandom_range(1, 6));
			end
		end
		idle_input(1);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		results_seen = 0;
		quiet_cycles = 0;
		stamp_ms = '0;
		step_max = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset state first, then a walk through every rule
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd0);
		send_event(MODE_DONE, 8'h00, 1'b0, 2'd0, 32'd0);
		for (int m = MODE_CLEAR + 1; m < 8; m++)
			send_event(3'(m), 8'hFF, 1'b1, 2'd3, 32'hFFFF_FFFF);
		idle_input(1);
		wait_drained();
		program_regs(32'd10, 32'd20, 8'd2);
		send_event(MODE_INTENT, 8'hFF, 1'b0, 2'd3, 32'd1);
		send_event(MODE_CLEAR, 8'h00, 1'b0, 2'd0, 32'd1);
		send_event(MODE_CLEAR, 8'h00, 1'b0, 2'd0, 32'd1);
		send_event(MODE_INTENT, 8'h12, 1'b1, KIND_COLOUR, 32'd2);
		send_event(MODE_INTENT, 8'h34, 1'b0, 2'd2, 32'd2);
		send_event(MODE_CLEAR, 8'h00, 1'b0, 2'd0, 32'd2);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd3);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd4);
		send_event(MODE_DONE, 8'h00, 1'b0, 2'd0, 32'd5);
		send_event(MODE_DETENT, 8'h56, 1'b0, 2'd0, 32'd100);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd105);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd110);
		send_event(MODE_DONE, 8'h00, 1'b0, 2'd0, 32'd111);
		send_event(MODE_INTENT, 8'hAB, 1'b0, 2'd2, 32'd112);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd112);
		send_event(MODE_DONE, 8'h00, 1'b0, 2'd0, 32'd200);
		send_event(MODE_INTENT, 8'h00, 1'b0, KIND_FAST, 32'd201);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd210);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd220);
		send_event(MODE_DONE, 8'h00, 1'b0, 2'd0, 32'd221);
		// detent stamped ahead of the tick clock counts as no time elapsed
		send_event(MODE_DETENT, 8'h77, 1'b0, 2'd0, 32'd1000);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd500);
		send_event(MODE_TICK, 8'h00, 1'b0, 2'd0, 32'd1010);
		idle_input(1);
		wait_drained();

		run_phase(32'd0, 32'd0, 8'd0, 32'd0, 5);
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, $urandom, 1000);
		run_phase(32'd20, 32'd30, 8'd3, 32'hFFFF_FF80, 8);
		run_phase(32'd5, 32'd60, 8'd1, 32'd1000, 10);
		run_phase($urandom_range(0, 40), $urandom_range(0, 40), 8'($urandom_range(0, 6)),
			$urandom, 15);
		run_phase($urandom, $urandom, 8'($urandom), $urandom, 32'h4000_0000);
		run_phase(32'h7FFF_FFFF, 32'h8000_0000, 8'd2, 32'd0, 20);
		run_phase(32'd10, 32'd10, 8'd4, $urandom, 6);

		repeat (10) @(posedge clk);
		if (model.errors == 0 && model.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
